>>> sv/fust_pkg.sv
// Package for the first unique symbol tracker.
// Holds symbol and count widths, count codes and the default alphabet size.
// No dependencies.
package fust_pkg;

  localparam int SYMBOLS_DEF = 256;
  localparam int SYM_W       = 8;
  localparam int CNT_W       = 2;

  // occurrence count, saturating at two
  typedef enum logic [CNT_W-1:0] {
    CNT_NONE = 2'd0,
    CNT_ONCE = 2'd1,
    CNT_MANY = 2'd2
  } cnt_code_t;

endpackage

>>> sv/first_unique_symbol_tracker.sv
// Top level of the first unique symbol tracker.
// Depends on fust_pkg and fust_ram.
//
// Usage:
//   Input channel (in_valid/in_ready, symbol_in) takes one byte of the stream
//   per transfer. Output channel (out_valid/out_ready, found, first_unique)
//   gives one result per byte: the oldest symbol seen exactly once so far, or
//   found = 0 with first_unique = 0.
//   Bytes of SYMBOLS or more are ignored and the current answer is repeated.
//   Order: on transfer the byte is registered and its count read; in S_READ
//   the count lands and, if the head of the candidate queue stays put, the
//   result is loaded. When the byte repeats the head symbol, the head is
//   dropped in the count cycle. Each further queue entry to check passes
//   S_POP_F (queue memory read), S_POP_C (count memory read for that symbol)
//   and S_POP_CHK; S_DONE then issues the result. Every symbol is popped at
//   most once. A new byte is taken only once the last result is loaded.
//   Reset: counts are cleared by a pass over the count memory, one entry per
//   cycle, over all SYMBOLS entries; in_ready stays low until it ends. A new
//   stream starts after reset.
//   Stall: one result register sits on the output. A new byte is taken while
//   it waits; the block holds the next result until the register frees up.
module first_unique_symbol_tracker
  import fust_pkg::*;
#(
  parameter int SYMBOLS = SYMBOLS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SYM_W-1:0] symbol_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output logic [SYM_W-1:0] first_unique
);

  localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int FW = $clog2(SYMBOLS + 1);
  localparam logic [AW-1:0]    LAST_SLOT = AW'(SYMBOLS - 1);
  localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOLS);
  localparam logic [FW-1:0]    FILL_ONE  = FW'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_POP_F,
    S_POP_C,
    S_POP_CHK,
    S_DONE
  } state_t;

  state_t state;

  logic [AW-1:0]    clr_idx;
  logic [AW-1:0]    head_idx;
  logic [AW-1:0]    tail_idx;
  logic [FW-1:0]    fill;
  logic [SYM_W-1:0] sym;
  logic [SYM_W-1:0] head_sym;
  logic [SYM_W-1:0] cand;

  logic             cnt_we;
  logic [AW-1:0]    cnt_waddr;
  logic [CNT_W-1:0] cnt_wdata;
  logic [AW-1:0]    cnt_raddr;
  logic [CNT_W-1:0] cnt_rdata;
  logic             fifo_we;
  logic [SYM_W-1:0] fifo_rdata;

  logic             out_free;
  logic             out_load;
  logic             in_range;
  logic             first_seen;
  logic             pop_head;
  logic [FW-1:0]    fill_after;
  logic [SYM_W-1:0] head_after;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot);
    return (slot == LAST_SLOT) ? '0 : slot + AW'(1);
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign in_range  = ({1'b0, symbol_in} < SYM_LIMIT);

  assign first_seen = (cnt_rdata == CNT_NONE);
  assign pop_head   = !first_seen && (fill != '0) && (sym == head_sym);
  assign fill_after = first_seen ? fill + FILL_ONE : fill;
  assign head_after = (first_seen && fill == '0) ? sym : head_sym;

  // a new result enters the output register this cycle
  assign out_load = out_free && (((state == S_READ) && !pop_head) || (state == S_DONE));

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = sym[AW-1:0];
    cnt_wdata = CNT_NONE;
    if (state == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx;
    end else if (state == S_READ) begin
      cnt_we    = 1'b1;
      cnt_wdata = first_seen ? CNT_ONCE : CNT_MANY;
    end
    cnt_raddr = (state == S_POP_C) ? fifo_rdata[AW-1:0] : symbol_in[AW-1:0];
    fifo_we   = (state == S_READ) && first_seen;
  end

  fust_ram #(
    .WIDTH (CNT_W),
    .DEPTH (SYMBOLS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  fust_ram #(
    .WIDTH (SYM_W),
    .DEPTH (SYMBOLS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail_idx),
    .wdata (sym),
    .raddr (head_idx),
    .rdata (fifo_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      head_idx  <= '0;
      tail_idx  <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            sym   <= symbol_in;
            state <= in_range ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          // count read for this byte has landed
          if (first_seen) begin
            tail_idx <= next_slot(tail_idx);
            fill     <= fill_after;
            head_sym <= head_after;
          end
          if (pop_head) begin
            head_idx <= next_slot(head_idx);
            fill     <= fill - FILL_ONE;
            state    <= (fill == FILL_ONE) ? S_DONE : S_POP_F;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            found        <= (fill_after != '0);
            first_unique <= (fill_after != '0) ? head_after : '0;
            state        <= S_IDLE;
          end else begin
            state <= S_DONE;
          end
        end
        S_POP_F: begin
          state <= S_POP_C;
        end
        S_POP_C: begin
          cand  <= fifo_rdata;
          state <= S_POP_CHK;
        end
        S_POP_CHK: begin
          if (cnt_rdata == CNT_MANY) begin
            // drop repeated symbol and look at the next entry
            head_idx <= next_slot(head_idx);
            fill     <= fill - FILL_ONE;
            state    <= (fill == FILL_ONE) ? S_DONE : S_POP_F;
          end else begin
            head_sym <= cand;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            found        <= (fill != '0);
            first_unique <= (fill != '0) ? head_sym : '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/fust_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Read during write to the same address returns the old contents.
// No dependencies.
module fust_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> dv/tb_first_unique_symbol_tracker.sv
// Testbench for first_unique_symbol_tracker: drives a byte stream, predicts the oldest
// once-seen symbol after every byte and checks each result in order.
// Depends on fust_pkg and the block's RTL.
module tb_first_unique_symbol_tracker;
  import fust_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ALPHA      = SYMBOLS_DEF;
  localparam int IDLE_PCT   = 37;
  localparam int RAND_ITEMS = 2000;
  localparam int DRAIN_MID  = 1200;
  localparam int STALL_MAX  = 5000;
  localparam int TAIL_WAIT  = 40;

  typedef struct packed {
    logic             found;
    logic [SYM_W-1:0] sym;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [SYM_W-1:0] symbol_in = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             found;
  logic [SYM_W-1:0] first_unique;

  first_unique_symbol_tracker #(.SYMBOLS(ALPHA)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .symbol_in    (symbol_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .first_unique (first_unique)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  cnt_code_t        sym_count [SYMBOLS_DEF];
  logic [SYM_W-1:0] cand_q [$];
  answer_t          answer_q [$];

  // stream generator state, kept apart from the predictor
  cnt_code_t        gen_count [SYMBOLS_DEF];
  logic [SYM_W-1:0] gen_once [$];
  logic [SYM_W-1:0] gen_seen [$];
  logic [SYM_W-1:0] gen_unseen [$];
  logic [SYM_W-1:0] pending_q [$];

  int errors  = 0;
  int issued  = 0;
  int dir_n   = 0;
  int stalled = 0;
  bit calm;

  assign calm = (issued >= 700) && (issued < 1000);

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic answer_t next_first_unique(input logic [SYM_W-1:0] sym);
    answer_t ans;
    if (int'(sym) < ALPHA) begin
      if (sym_count[sym] == CNT_NONE) begin
        sym_count[sym] = CNT_ONCE;
        cand_q.push_back(sym);
      end else begin
        sym_count[sym] = CNT_MANY;
      end
      // drop repeated symbols from the head
      while (cand_q.size() > 0 && sym_count[cand_q[0]] == CNT_MANY)
        void'(cand_q.pop_front());
    end
    ans.found = (cand_q.size() > 0);
    ans.sym   = ans.found ? cand_q[0] : '0;
    return ans;
  endfunction

  task automatic queue_symbol(input logic [SYM_W-1:0] sym);
    pending_q.push_back(sym);
    if (int'(sym) < ALPHA) begin
      if (gen_count[sym] == CNT_NONE) begin
        gen_count[sym] = CNT_ONCE;
        gen_once.push_back(sym);
        gen_seen.push_back(sym);
        foreach (gen_unseen[i])
          if (gen_unseen[i] == sym) begin
            gen_unseen.delete(i);
            break;
          end
      end else if (gen_count[sym] == CNT_ONCE) begin
        gen_count[sym] = CNT_MANY;
        foreach (gen_once[i])
          if (gen_once[i] == sym) begin
            gen_once.delete(i);
            break;
          end
      end
    end
  endtask

  // driver: predict on each input transfer, then present the next byte
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        answer_q.push_back(next_first_unique(symbol_in));
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 &&
            !((issued == dir_n || issued == DRAIN_MID) && answer_q.size() != 0) &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid  <= 1'b1;
          symbol_in <= pending_q.pop_front();
          issued++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected result, first_unique", first_unique, -1);
        end else begin
          answer_t want;
          want = answer_q.pop_front();
          if (found !== want.found)
            report_mismatch("found", found, want.found);
          if (first_unique !== want.sym)
            report_mismatch("first_unique", first_unique, want.sym);
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stalled <= 0;
    else
      stalled <= stalled + 1;
    if (stalled >= STALL_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int r;
    logic [SYM_W-1:0] pick;
    for (int s = 0; s < SYMBOLS_DEF; s++) begin
      sym_count[s] = CNT_NONE;
      gen_count[s] = CNT_NONE;
      if (s < ALPHA)
        gen_unseen.push_back(SYM_W'(s));
    end

    // directed: zero byte, extremes, head repeats, multi-entry pops, empty queue
    queue_symbol(8'h00);
    queue_symbol(8'hFF);
    queue_symbol(8'h00);
    queue_symbol(8'h00);
    queue_symbol(8'hFF);
    queue_symbol(8'h01);
    queue_symbol(8'h02);
    queue_symbol(8'h03);
    queue_symbol(8'h02);
    queue_symbol(8'h01);
    queue_symbol(8'h03);
    queue_symbol(8'h80);
    queue_symbol(8'h7F);
    queue_symbol(8'h55);
    queue_symbol(8'hAA);
    queue_symbol(8'h7F);
    queue_symbol(8'hAA);
    queue_symbol(8'h80);
    queue_symbol(8'h55);
    queue_symbol(SYM_W'(ALPHA - 1));
    dir_n = pending_q.size();

    // random: fresh symbols, repeats of live candidates or of any seen symbol, some noise
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (gen_unseen.size() > 0 && r < 12) begin
        pick = gen_unseen[$urandom_range(0, gen_unseen.size() - 1)];
      end else if (gen_once.size() > 0 && r < 35) begin
        pick = gen_once[0];
      end else if (gen_once.size() > 0 && r < 55) begin
        pick = gen_once[$urandom_range(0, gen_once.size() - 1)];
      end else if (gen_seen.size() > 0 && r < 85) begin
        pick = gen_seen[$urandom_range(0, gen_seen.size() - 1)];
      end else begin
        pick = SYM_W'($urandom_range(0, 255));
      end
      queue_symbol(pick);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || in_valid || answer_q.size() > 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (answer_q.size() != 0)
      report_mismatch("results missing", 0, answer_q.size());
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
